@@ design/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 transcoder
// Item formats on both channels, the per-byte emission plan and code constants.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Code constants
    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;

    // Input item: one UTF-8 byte
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } in_item_t;

    // Output item: one UTF-16 code unit
    typedef struct packed {
        logic [15:0] utf16_unit;
        logic        final_unit;
    } out_item_t;

    // Emission plan for one byte, in order:
    //   n_lead replacements, n_body units (body0, body1),
    //   n_tail replacements, then the terminator if term is set.
    typedef struct packed {
        logic [1:0]  n_lead;
        logic [1:0]  n_body;
        logic [15:0] body0;
        logic [15:0] body1;
        logic [1:0]  n_tail;
        logic        term;
    } plan_t;

endpackage

@@ design/utf8_to_utf16_transcoder.sv @@
// Path: an accepted byte is registered in the input register and moves on into the result
//   buffer once that can load; the buffer then offers its first code unit.
// Throughput: one byte per cycle while each byte yields at most one unit and the output
//   is not stalled; a byte yielding k units (k up to 5) occupies the single output port.
// Reset: rst_n clears the pending sequence and empties the input and result stages.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: streaming UTF-8 to UTF-16 converter
// Input register, sequence decoder and a result buffer that drains per unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  u8u16_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output u8u16_pkg::out_item_t  out_data
);

    u8u16_pkg::in_item_t hold_reg;
    logic                hold_valid_reg;
    logic                move;
    logic                can_load;
    u8u16_pkg::plan_t    plan;

    // Move the held byte into the result buffer when it frees up
    assign move     = hold_valid_reg && can_load;
    assign in_stall = hold_valid_reg && !can_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            hold_reg <= in_data;
        end
    end

    u8u16_decoder u_decoder
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (hold_reg),
        .advance (move),
        .plan    (plan)
    );

    u8u16_out_seq u_out_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .plan     (plan),
        .load     (move),
        .can_load (can_load),
        .valid    (out_valid),
        .stall    (out_stall),
        .data     (out_data)
    );

`ifndef ASSERT_OFF
    // a stalled unit stays offered and unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output unit dropped or changed");

    // the terminator carries a zero unit
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.final_unit |-> (out_data.utf16_unit == 16'd0))
        else $error("terminator with nonzero unit");

    // input stalls only while a byte is held back
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> hold_valid_reg && out_valid)
        else $error("input stalled without a waiting byte");
`endif

endmodule

@@ design/u8u16_decoder.sv @@
// ----------------------------------------------------------------------------
// u8u16_decoder: UTF-8 sequence decoder
// Holds the pending sequence state and turns one byte into an emission plan.
// State advances when the plan is taken by the output buffer.
// ----------------------------------------------------------------------------
module u8u16_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8u16_pkg::in_item_t  item,
    input  logic                 advance,
    output u8u16_pkg::plan_t     plan
);

    logic [20:0] point_reg;
    logic [20:0] point_next;
    logic [1:0]  need_reg;
    logic [1:0]  need_next;
    logic [1:0]  held_reg;
    logic [1:0]  held_next;

    logic        is_cont;
    logic [20:0] acc;
    logic [20:0] supp_off;
    logic [1:0]  mid_need;
    logic [1:0]  mid_held;
    logic [7:0]  b;

    // Accumulated code point, its offset into the supplementary planes, continuation test
    assign acc      = {point_reg[14:0], item.byte_in[5:0]};
    assign supp_off = acc - u8u16_pkg::SUPP_BASE;
    assign b        = item.byte_in;
    assign is_cont  = (need_reg != 2'd0) && (b[7:6] == 2'b10);

    // Plan and next state
    always_comb
    begin
        plan       = '0;
        point_next = point_reg;
        mid_need   = need_reg;
        mid_held   = held_reg;

        if (is_cont)
        begin
            if (need_reg == 2'd1)
            begin
                // sequence complete
                point_next = '0;
                mid_need   = 2'd0;
                mid_held   = 2'd0;
                if (acc[20:16] == 5'd0)
                begin
                    plan.n_body = 2'd1;
                    plan.body0  = acc[15:0];
                end
                else if (acc <= u8u16_pkg::MAX_CP)
                begin
                    plan.n_body = 2'd2;
                    plan.body0  = u8u16_pkg::HI_SURR_BASE | {6'd0, supp_off[19:10]};
                    plan.body1  = u8u16_pkg::LO_SURR_BASE | {6'd0, supp_off[9:0]};
                end
                else
                begin
                    plan.n_body = 2'd1;
                    plan.body0  = u8u16_pkg::REPL_CHAR;
                end
            end
            else
            begin
                point_next = acc;
                mid_need   = need_reg - 2'd1;
                mid_held   = held_reg + 2'd1;
            end
        end
        else
        begin
            // flush a broken sequence: lead plus each held byte
            plan.n_lead = (need_reg != 2'd0) ? (held_reg + 2'd1) : 2'd0;
            point_next  = '0;
            mid_need    = 2'd0;
            mid_held    = 2'd0;
            if (b[7] == 1'b0)
            begin
                plan.n_body = 2'd1;
                plan.body0  = {8'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                point_next = {16'd0, b[4:0]};
                mid_need   = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                point_next = {17'd0, b[3:0]};
                mid_need   = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                point_next = {18'd0, b[2:0]};
                mid_need   = 2'd3;
            end
            else
            begin
                plan.n_body = 2'd1;
                plan.body0  = u8u16_pkg::REPL_CHAR;
            end
        end

        // end of string: flush a truncated sequence, then terminate
        if (item.end_of_string)
        begin
            plan.n_tail = (mid_need != 2'd0) ? (mid_held + 2'd1) : 2'd0;
            plan.term   = 1'b1;
            point_next  = '0;
            need_next   = 2'd0;
            held_next   = 2'd0;
        end
        else
        begin
            need_next = mid_need;
            held_next = mid_held;
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg <= '0;
            need_reg  <= '0;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            point_reg <= point_next;
            need_reg  <= need_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ design/u8u16_out_seq.sv @@
// ----------------------------------------------------------------------------
// u8u16_out_seq: result buffer and unit sequencer
// Holds one emission plan and hands out its code units one per cycle while not stalled.
// ----------------------------------------------------------------------------
module u8u16_out_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8u16_pkg::plan_t      plan,
    input  logic                  load,
    output logic                  can_load,
    output logic                  valid,
    input  logic                  stall,
    output u8u16_pkg::out_item_t  data
);

    u8u16_pkg::plan_t plan_reg;
    logic             valid_reg;
    logic [3:0]       idx_reg;

    logic [3:0] end_lead;
    logic [3:0] end_body;
    logic [3:0] end_tail;
    logic [3:0] total;
    logic [3:0] new_total;
    logic       last_take;

    // Unit boundaries inside the held plan
    assign end_lead  = {2'd0, plan_reg.n_lead};
    assign end_body  = end_lead + {2'd0, plan_reg.n_body};
    assign end_tail  = end_body + {2'd0, plan_reg.n_tail};
    assign total     = end_tail + {3'd0, plan_reg.term};
    assign new_total = {2'd0, plan.n_lead} + {2'd0, plan.n_body}
                     + {2'd0, plan.n_tail} + {3'd0, plan.term};

    assign valid     = valid_reg;
    assign last_take = valid_reg && !stall && ((idx_reg + 4'd1) == total);
    assign can_load  = !valid_reg || last_take;

    // Select the current unit
    always_comb
    begin
        data.final_unit = 1'b0;
        if (idx_reg < end_lead)
        begin
            data.utf16_unit = u8u16_pkg::REPL_CHAR;
        end
        else if (idx_reg < end_body)
        begin
            data.utf16_unit = (idx_reg == end_lead) ? plan_reg.body0 : plan_reg.body1;
        end
        else if (idx_reg < end_tail)
        begin
            data.utf16_unit = u8u16_pkg::REPL_CHAR;
        end
        else
        begin
            data.utf16_unit = 16'd0;
            data.final_unit = 1'b1;
        end
    end

    // Buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= (new_total != 4'd0);
            idx_reg   <= '0;
        end
        else if (last_take)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (valid_reg && !stall)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    // Plan payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan;
        end
    end

endmodule

@@ tb/utf16_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_unit_checker: predicts and checks the UTF-16 units of the transcoder
// Watches both channels. Each accepted byte is decoded by a local copy of the
// sequence state, and the expected units are queued. Each accepted output
// unit is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module utf16_unit_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  u8u16_pkg::in_item_t   in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  u8u16_pkg::out_item_t  out_data,
    output int                    errors,
    output int                    units_pending
);

    localparam logic [20:0] BMP_LIMIT = 21'h00FFFF;

    // Decoder state: gathered code point bits, continuation bytes left and held
    logic [20:0] seq_point;
    logic [1:0]  conts_left;
    logic [1:0]  conts_held;

    u8u16_pkg::out_item_t expected_units [$];
    u8u16_pkg::out_item_t want;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic push_unit(input logic [15:0] cu, input logic fin);
        u8u16_pkg::out_item_t u;
        u.utf16_unit = cu;
        u.final_unit = fin;
        expected_units = {expected_units, u};
    endtask

    // One code point: BMP unit, surrogate pair, or replacement if out of range
    task automatic push_point(input logic [20:0] cp);
        logic [20:0] offs;
        offs = cp - u8u16_pkg::SUPP_BASE;
        if (cp <= BMP_LIMIT)
            push_unit(cp[15:0], 1'b0);
        else if (cp <= u8u16_pkg::MAX_CP)
        begin
            push_unit(u8u16_pkg::HI_SURR_BASE | {6'd0, offs[19:10]}, 1'b0);
            push_unit(u8u16_pkg::LO_SURR_BASE | {6'd0, offs[9:0]}, 1'b0);
        end
        else
            push_unit(u8u16_pkg::REPL_CHAR, 1'b0);
    endtask

    // Abandon a pending sequence: one replacement for the lead and each held byte
    task automatic drop_pending();
        if (conts_left != 2'd0)
        begin
            repeat (int'(conts_held) + 1)
                push_unit(u8u16_pkg::REPL_CHAR, 1'b0);
            seq_point  = '0;
            conts_left = 2'd0;
            conts_held = 2'd0;
        end
    endtask

    // Byte seen with no sequence pending
    task automatic open_lead(input logic [7:0] b);
        casez (b)
            8'b0???_????: push_unit({8'd0, b}, 1'b0);
            8'b110?_????:
            begin
                seq_point  = {16'd0, b[4:0]};
                conts_left = 2'd1;
                conts_held = 2'd0;
            end
            8'b1110_????:
            begin
                seq_point  = {17'd0, b[3:0]};
                conts_left = 2'd2;
                conts_held = 2'd0;
            end
            8'b1111_0???:
            begin
                seq_point  = {18'd0, b[2:0]};
                conts_left = 2'd3;
                conts_held = 2'd0;
            end
            default: push_unit(u8u16_pkg::REPL_CHAR, 1'b0);
        endcase
    endtask

    // Expected units for one accepted byte
    task automatic decode_byte(input u8u16_pkg::in_item_t item);
        if (conts_left != 2'd0 && item.byte_in[7:6] == 2'b10)
        begin
            seq_point  = {seq_point[14:0], item.byte_in[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0)
            begin
                push_point(seq_point);
                seq_point  = '0;
                conts_held = 2'd0;
            end
            else
                conts_held = conts_held + 2'd1;
        end
        else
        begin
            drop_pending();
            open_lead(item.byte_in);
        end
        // End of string: flush a truncated sequence, then the terminator
        if (item.end_of_string)
        begin
            drop_pending();
            push_unit(16'd0, 1'b1);
        end
    endtask

    // Channel monitor: input side first, then compare the output unit
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_point  = '0;
            conts_left = 2'd0;
            conts_held = 2'd0;
            expected_units.delete();
            errors = 0;
            units_pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_units.size() == 0)
                    report_mismatch($sformatf("unit %h final %b with none expected",
                                              out_data.utf16_unit, out_data.final_unit));
                else
                begin
                    want = expected_units.pop_front();
                    if (out_data.utf16_unit !== want.utf16_unit)
                        report_mismatch($sformatf("utf16_unit %h, expected %h",
                                                  out_data.utf16_unit, want.utf16_unit));
                    if (out_data.final_unit !== want.final_unit)
                        report_mismatch($sformatf("final_unit %b, expected %b on unit %h",
                                                  out_data.final_unit, want.final_unit,
                                                  want.utf16_unit));
                end
            end
            units_pending <= expected_units.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top of the UTF-8 to UTF-16 transcoder testbench
// Drives a directed byte list and then random UTF-8 text, mostly well formed
// with stray, broken and cut-short sequences mixed in, under random gaps and
// output stalls. The checker module predicts and compares; this top decides
// the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_BYTES = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    u8u16_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_stall;
    u8u16_pkg::out_item_t out_data;
    int                   errors;
    int                   units_pending;

    bit                   in_idle_on;

    utf8_to_utf16_transcoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    utf16_unit_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .errors        (errors),
        .units_pending (units_pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit idle_on);
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 5);
    endfunction

    // Output stall pattern: phases with and without stalls
    initial
    begin
        int  hold;
        int  span;
        bit  stall_on;
        hold      = 0;
        span      = 0;
        stall_on  = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span     = $urandom_range(200, 20);
                stall_on = ($urandom_range(3) != 0);
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                hold = pick_gap(stall_on);
                out_stall <= (hold > 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    // Offer one byte and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = pick_gap(in_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, eos};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Lead byte of a sequence of len bytes; 4-byte leads sometimes out of range
    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, ($urandom_range(2) == 0) ? 3'($urandom)
                                                                 : 3'($urandom_range(4))};
        endcase
    endfunction

    // Directed: extremes, all lengths, surrogates, range limit, bad and cut sequences
    task automatic send_directed();
        logic [8:0] plan [29] = '{
            {8'h00, 1'b0}, {8'h7F, 1'b1},
            {8'hC2, 1'b0}, {8'hA9, 1'b0}, {8'hE2, 1'b0}, {8'h82, 1'b0},
            {8'hAC, 1'b0}, {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0},
            {8'h80, 1'b1},
            {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
            {8'hF4, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b1},
            {8'h80, 1'b0}, {8'hFF, 1'b0}, {8'hE2, 1'b0}, {8'h82, 1'b0},
            {8'h41, 1'b1},
            {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'hFF, 1'b1},
            {8'hC2, 1'b1}
        };
        foreach (plan[i])
            send_item(plan[i][8:1], plan[i][0]);
    endtask

    // Random text: characters of every length, with stray and broken bytes
    task automatic send_random_text(input int target);
        logic [7:0] seq [4];
        int         n_seq;
        int         full_len;
        int         kind;
        int         sent;
        bit         eos_here;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                seq[0] = 8'($urandom_range(127));
                n_seq  = 1;
            end
            else if (kind < 82)
            begin
                full_len = (kind < 50) ? 2 : (kind < 68) ? 3 : 4;
                seq[0]   = lead_byte(full_len);
                for (int i = 1; i < full_len; i++)
                    seq[i] = cont_byte();
                n_seq = full_len;
            end
            else if (kind < 88)
            begin
                seq[0] = 8'($urandom_range(255, 128));
                n_seq  = 1;
            end
            else if (kind < 96)
            begin
                // sequence cut short; the next byte breaks it or the string ends
                full_len = $urandom_range(4, 2);
                seq[0]   = lead_byte(full_len);
                n_seq    = $urandom_range(full_len - 1, 1);
                for (int i = 1; i < n_seq; i++)
                    seq[i] = cont_byte();
            end
            else
            begin
                seq[0] = 8'($urandom);
                n_seq  = 1;
            end
            eos_here = ($urandom_range(9) == 0) || (sent + n_seq >= target);
            for (int i = 0; i < n_seq; i++)
                send_item(seq[i], eos_here && (i == n_seq - 1));
            sent += n_seq;
            if (eos_here)
                in_idle_on = ($urandom_range(3) != 0);
        end
    endtask

    // Reset, stimulus, drain and verdict
    initial
    begin
        int drain_cycles;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        in_idle_on  = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random_text(RANDOM_BYTES);
        in_valid <= 1'b0;

        // wait for every expected unit, then watch for stray output
        drain_cycles = 0;
        @(posedge clk);
        while (units_pending != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && units_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
